>>> rtl/tcht_pkg.sv
// ---------------------------------------------------------------------------
// tcht_pkg - shared types for the task chain hyperperiod table
// Item and result payloads, lcm unit request/response, field widths.
// ---------------------------------------------------------------------------
package tcht_pkg;

  localparam int HP_W        = 63;
  localparam int ID_W        = 16;
  localparam int PERIOD_W    = 32;
  localparam int COUNT_OUT_W = 5;

  localparam logic [HP_W-1:0] HP_MAX = {HP_W{1'b1}};

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic                command;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] task_period;
  } tcht_item_t;

  typedef struct packed {
    logic [HP_W-1:0]        hyperperiod;
    logic                   in_chain;
    logic                   is_last;
    logic [COUNT_OUT_W-1:0] task_count;
    logic                   full_reject;
    logic                   overflow;
  } tcht_result_t;

  typedef struct packed {
    logic                start;
    logic [HP_W-1:0]     old;
    logic [PERIOD_W-1:0] period;
  } tcht_lcm_req_t;

  typedef struct packed {
    logic            done;
    logic            sat;
    logic [HP_W-1:0] value;
  } tcht_lcm_rsp_t;

endpackage

>>> rtl/tcht_ram.sv
// ---------------------------------------------------------------------------
// tcht_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module tcht_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/tcht_lcm_unit.sv
// ---------------------------------------------------------------------------
// tcht_lcm_unit - iterative lcm fold
// old / gcd(old, p) * p with 63-bit saturation. Binary gcd one step per
// cycle, restoring divide two quotient bits per cycle, 64x32 multiply as
// two 32x32 partial products on one shared multiplier.
// ---------------------------------------------------------------------------
module tcht_lcm_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  tcht_pkg::tcht_lcm_req_t req,
  output tcht_pkg::tcht_lcm_rsp_t rsp
);

  import tcht_pkg::*;

  typedef enum logic [5:0] {
    L_IDLE   = 6'b000001,
    L_GCD    = 6'b000010,
    L_DIV    = 6'b000100,
    L_MUL_LO = 6'b001000,
    L_MUL_HI = 6'b010000,
    L_FIN    = 6'b100000
  } lcm_state_t;

  lcm_state_t state;

  logic [HP_W-1:0]     ga;
  logic [PERIOD_W-1:0] gb;
  logic [PERIOD_W-1:0] pr;
  logic [4:0]          k;
  logic [PERIOD_W-1:0] g;
  logic [PERIOD_W-1:0] rem;
  logic [63:0]         dq;      // dividend in, quotient out
  logic [4:0]          dcnt;
  logic [63:0]         pl;
  logic [63:0]         ph;

  // gcd step
  logic                eq;
  logic                ga_gt;
  logic [HP_W-1:0]     ga_diff;
  logic [PERIOD_W-1:0] gb_diff;
  logic [63:0]         gsh;

  assign eq      = (ga == {{(HP_W-PERIOD_W){1'b0}}, gb});
  assign ga_gt   = (ga > {{(HP_W-PERIOD_W){1'b0}}, gb});
  assign ga_diff = ga - {{(HP_W-PERIOD_W){1'b0}}, gb};
  assign gb_diff = gb - ga[PERIOD_W-1:0];
  assign gsh     = {32'b0, gb} << k;

  // two restoring divide steps
  logic [PERIOD_W:0]   r1, r1s, r2, r2s;
  logic                ge1, ge2;
  logic [PERIOD_W-1:0] rem1, rem2;

  always_comb begin
    r1   = {rem, dq[63]};
    ge1  = (r1 >= {1'b0, g});
    r1s  = ge1 ? (r1 - {1'b0, g}) : r1;
    rem1 = r1s[PERIOD_W-1:0];
    r2   = {rem1, dq[62]};
    ge2  = (r2 >= {1'b0, g});
    r2s  = ge2 ? (r2 - {1'b0, g}) : r2;
    rem2 = r2s[PERIOD_W-1:0];
  end

  // shared multiplier
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [95:0] sum;

  assign mul_a = (state == L_MUL_LO) ? dq[31:0] : dq[63:32];
  assign prod  = 64'(mul_a) * 64'(pr);
  assign sum   = {ph, 32'b0} + {32'b0, pl};

  assign rsp.done  = (state == L_FIN);
  assign rsp.sat   = |sum[95:HP_W];
  assign rsp.value = rsp.sat ? HP_MAX : sum[HP_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE:   if (req.start) state <= L_GCD;
        L_GCD:    if (eq) state <= L_DIV;
        L_DIV:    if (&dcnt) state <= L_MUL_LO;
        L_MUL_LO: state <= L_MUL_HI;
        L_MUL_HI: state <= L_FIN;
        L_FIN:    state <= L_IDLE;
        default:  state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        ga <= req.old;
        gb <= req.period;
        pr <= req.period;
        dq <= {1'b0, req.old};
        k  <= '0;
      end
      L_GCD: begin
        if (eq) begin
          g    <= gsh[PERIOD_W-1:0];
          rem  <= '0;
          dcnt <= '0;
        end else if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          k  <= k + 5'd1;
        end else if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga_gt) begin
          ga <= ga_diff >> 1;
        end else begin
          gb <= gb_diff >> 1;
        end
      end
      L_DIV: begin
        rem  <= rem2;
        dq   <= {dq[61:0], ge1, ge2};
        dcnt <= dcnt + 5'd1;
      end
      L_MUL_LO: pl <= prod;
      L_MUL_HI: ph <= prod;
      default: ;
    endcase
  end

endmodule

>>> rtl/task_chain_hyperperiod_table.sv
// ---------------------------------------------------------------------------
// task_chain_hyperperiod_table - task id chain with running hyperperiod
// Add appends an id and folds its period into the running lcm; lookup
// scans the id table. Every item returns hyperperiod, count and flags.
// ---------------------------------------------------------------------------
//
//  channel  dir  handshake                 payload
//  -------  ---  ------------------------  -------------------------------
//  item     in   start & !busy             item   (tcht_item_t)
//  result   out  done, one cycle, no stall result (tcht_result_t)
//  config   in   cfg_we, no wait           cfg_data (empty_hyperperiod)
//
//  Steps, accept to done:
//    add, first / rejected / saturated / zero period : straight to reply
//    add with fold : binary gcd on the lcm unit (one bit per step), then
//                    restoring divide, multiply and finish, then reply
//    lookup : scan, one id table read per cycle; straight to reply if empty
//  Reset is synchronous; the id table needs no clearing pass.
//  The receiver cannot stall: done lasts one cycle, and the next item may
//  be accepted in that same cycle.
//
module task_chain_hyperperiod_table #(
  parameter int MAX_TASKS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  tcht_pkg::tcht_item_t   item,
  output logic                   done,
  output tcht_pkg::tcht_result_t result,
  input  logic                   cfg_we,
  input  logic [62:0]            cfg_data
);

  import tcht_pkg::*;

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int AW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FOLD  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_REPLY = 4'b1000
  } state_t;

  state_t state;

  // architectural state
  logic [CNT_W-1:0] count;
  logic [ID_W-1:0]  last_id;
  logic [HP_W-1:0]  lcm;
  logic             overflow_seen;
  logic [HP_W-1:0]  empty_hp;

  // per-item working registers
  logic [AW-1:0]    ptr;       // id table entry whose read data is due
  logic [ID_W-1:0]  id_q;
  logic             found_q;
  logic             last_q;
  logic             reject_q;

  logic             accept;
  logic             is_add;
  logic             full;
  logic             fold_go;
  logic             scan_end;
  logic [ID_W-1:0]  rd_data;
  logic [AW-1:0]    rd_addr;

  tcht_lcm_req_t    lcm_req;
  tcht_lcm_rsp_t    lcm_rsp;

  // an item can enter while the previous result is on the ports
  assign busy   = !(state == S_IDLE || state == S_REPLY);
  assign accept = start && !busy;
  assign is_add = (item.command == CMD_ADD);
  assign full   = (count >= CNT_W'(MAX_TASKS));

  // fold through the lcm unit only when no shortcut applies:
  // first task, sticky saturation, or a zero on either side
  assign fold_go = accept && is_add && !full && (count != '0) && !overflow_seen &&
                   (lcm != '0) && (item.task_period != '0);

  assign lcm_req.start  = fold_go;
  assign lcm_req.old    = lcm;
  assign lcm_req.period = item.task_period;

  tcht_lcm_unit u_lcm (
    .clk (clk),
    .rst (rst),
    .req (lcm_req),
    .rsp (lcm_rsp)
  );

  // id table: written only on add accept, read data used only by a scan, so the
  // two never touch the same entry in overlapping cycles
  assign rd_addr  = (state == S_SCAN) ? AW'(ptr + 1'b1) : '0;
  assign scan_end = ((CNT_W'(ptr) + 1'b1) == count);

  tcht_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_TASKS)
  ) u_id_table (
    .clk   (clk),
    .we    (accept && is_add && !full),
    .waddr (count[AW-1:0]),
    .wdata (item.task_id),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      last_id       <= '0;
      lcm           <= '0;
      overflow_seen <= 1'b0;
      empty_hp      <= '0;
      ptr           <= '0;
    end else begin
      if (cfg_we) begin
        empty_hp <= cfg_data;
      end
      unique case (state) inside
        S_IDLE, S_REPLY: begin
          if (accept) begin
            ptr <= '0;
            if (is_add) begin
              if (full) begin
                state <= S_REPLY;
              end else begin
                count   <= count + 1'b1;
                last_id <= item.task_id;
                if (count == '0) begin
                  lcm <= HP_W'(item.task_period);
                end else if (overflow_seen) begin
                  lcm <= HP_MAX;
                end else if ((lcm == '0) || (item.task_period == '0)) begin
                  lcm <= '0;
                end
                state <= fold_go ? S_FOLD : S_REPLY;
              end
            end else begin
              state <= (count == '0) ? S_REPLY : S_SCAN;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_FOLD: begin
          if (lcm_rsp.done) begin
            lcm <= lcm_rsp.value;
            if (lcm_rsp.sat) begin
              overflow_seen <= 1'b1;
            end
            state <= S_REPLY;
          end
        end
        S_SCAN: begin
          ptr <= ptr + 1'b1;
          if (scan_end) begin
            state <= S_REPLY;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id_q     <= item.task_id;
      found_q  <= 1'b0;
      last_q   <= !is_add && (count != '0) && (item.task_id == last_id);
      reject_q <= is_add && full;
    end else if (state == S_SCAN && rd_data == id_q) begin
      found_q <= 1'b1;
    end
  end

  // result comes straight from registers during the reply cycle
  assign done               = (state == S_REPLY);
  assign result.hyperperiod = (count == '0) ? empty_hp : lcm;
  assign result.in_chain    = found_q;
  assign result.is_last     = last_q;
  assign result.task_count  = COUNT_OUT_W'(count);
  assign result.full_reject = reject_q;
  assign result.overflow    = overflow_seen;

`ifndef ASSERT_OFF
  a_overflow_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |=> overflow_seen)
    else $error("overflow flag cleared");

  a_saturated_holds: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (lcm == HP_MAX))
    else $error("hyperperiod left saturation");

  a_reject_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && is_add && full) |=> $stable(count))
    else $error("rejected add changed task count");

  a_fold_done_in_fold: assert property (@(posedge clk) disable iff (rst)
    lcm_rsp.done |-> (state == S_FOLD))
    else $error("lcm unit finished outside fold");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench - task chain hyperperiod table
// Directed then random add and lookup items across three sender idle mixes.
// A scoreboard class predicts every result from the accepted items and checks
// the strobed results in order, field by field.
// ---------------------------------------------------------------------------
module testbench;
  import tcht_pkg::*;

  localparam int MAX_TASKS    = 16;
  // The limit allows for every item being the slowest (full gcd + divide + multiply)
  // after the longest sender gap, taken four times over.
  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int TAIL_CYCLES  = 200;
  localparam int MAX_REPORTS  = 40;
  // From this many stored tasks on, added periods are random, or 1 or all ones, to force saturation.
  localparam int SMOOTH_UNTIL = 10;

  // Predicts each result from the accepted item and holds the results due.
  class hyperperiod_tracker;
    logic [HP_W-1:0] empty_hp;
    logic [ID_W-1:0] chain_ids[$];
    logic [ID_W-1:0] newest_id;
    logic [HP_W-1:0] lcm_now;
    bit              sat_seen;
    tcht_result_t    expected_results[$];
    int              errors;

    function new();
      empty_hp  = '0;
      newest_id = '0;
      lcm_now   = '0;
      sat_seen  = 1'b0;
      errors    = 0;
    endfunction

    function logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      return a;
    endfunction

    // lcm = old / gcd(old, p) * p, saturating; sticky once saturated
    function void fold_period(logic [PERIOD_W-1:0] p);
      logic [63:0] wide_p;
      logic [63:0] wide_lcm;
      logic [63:0] g;
      logic [63:0] q;
      logic [63:0] prod;
      wide_p   = {32'd0, p};
      wide_lcm = {1'b0, lcm_now};
      if (sat_seen) begin
        lcm_now = HP_MAX;
        return;
      end
      if (lcm_now == 0 || p == 0) begin
        lcm_now = '0;
        return;
      end
      g = gcd64(wide_lcm, wide_p);
      q = wide_lcm / g;
      if (q > {1'b0, HP_MAX} / wide_p) begin
        lcm_now  = HP_MAX;
        sat_seen = 1'b1;
      end else begin
        prod    = q * wide_p;
        lcm_now = prod[HP_W-1:0];
      end
    endfunction

    function void note_accepted_item(tcht_item_t it);
      tcht_result_t r;
      r = '0;
      if (it.command == CMD_ADD) begin
        if (chain_ids.size() >= MAX_TASKS) begin
          r.full_reject = 1'b1;
        end else begin
          if (chain_ids.size() == 0) lcm_now = {31'd0, it.task_period};
          else fold_period(it.task_period);
          chain_ids = {chain_ids, it.task_id};
          newest_id = it.task_id;
        end
      end else if (chain_ids.size() > 0) begin
        foreach (chain_ids[i]) begin
          if (chain_ids[i] == it.task_id) r.in_chain = 1'b1;
        end
        r.is_last = (it.task_id == newest_id);
      end
      r.hyperperiod = (chain_ids.size() == 0) ? empty_hp : lcm_now;
      r.task_count  = COUNT_OUT_W'(chain_ids.size());
      r.overflow    = sat_seen;
      expected_results = {expected_results, r};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(tcht_result_t got);
      tcht_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing due: %p", got));
        return;
      end
      want = expected_results.pop_front();
      if (got.hyperperiod !== want.hyperperiod)
        report($sformatf("hyperperiod %0d, want %0d", got.hyperperiod, want.hyperperiod));
      if (got.in_chain !== want.in_chain)
        report($sformatf("in_chain %b, want %b", got.in_chain, want.in_chain));
      if (got.is_last !== want.is_last)
        report($sformatf("is_last %b, want %b", got.is_last, want.is_last));
      if (got.task_count !== want.task_count)
        report($sformatf("task_count %0d, want %0d", got.task_count, want.task_count));
      if (got.full_reject !== want.full_reject)
        report($sformatf("full_reject %b, want %b", got.full_reject, want.full_reject));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow %b, want %b", got.overflow, want.overflow));
    endtask
  endclass

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              start    = 1'b0;
  logic              busy;
  tcht_item_t        item     = '0;
  logic              done;
  tcht_result_t      result;
  logic              cfg_we   = 1'b0;
  logic [HP_W-1:0]   cfg_data = '0;
  int unsigned       cycle_count = 0;

  hyperperiod_tracker tracker = new();

  task_chain_hyperperiod_table #(
    .MAX_TASKS (MAX_TASKS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Monitor. Values read here are the ones from before the edge, so an item
  // counts as accepted exactly when start was high and busy low. A result and
  // a new item may land on the same edge; the FIFO keeps them in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note_accepted_item(item);
      if (done) tracker.check_result(result);
    end
  end

  // Present an item and hold it until accepted. start stays high on return so
  // back-to-back items never drop it; pause/drain lower it.
  task automatic send_item(tcht_item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every result due has come back; leaves the block idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (tracker.expected_results.size() != 0);
  endtask

  // Only called while idle (after drain), so no item sees a half-written value.
  task automatic write_cfg(logic [HP_W-1:0] value);
    cfg_we           <= 1'b1;
    cfg_data         <= value;
    tracker.empty_hp  = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic tcht_item_t make_item(logic cmd, logic [ID_W-1:0] id,
                                           logic [PERIOD_W-1:0] period);
    tcht_item_t it;
    it.command     = cmd;
    it.task_id     = id;
    it.task_period = period;
    return it;
  endfunction

  // Periods built from small primes keep the lcm growing slowly, so the gcd
  // path sees shared factors without saturating right away.
  function automatic logic [PERIOD_W-1:0] smooth_period();
    logic [PERIOD_W-1:0] p;
    p = 1;
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 5))
        0: p = p * 2;
        1: p = p * 3;
        2: p = p * 5;
        3: p = p * 7;
        4: p = p * 11;
        default: p = p * 13;
      endcase
    end
    return p;
  endfunction

  function automatic tcht_item_t random_item(int add_pct);
    tcht_item_t it;
    int         pick;
    int         stored;
    stored         = tracker.chain_ids.size();
    pick           = $urandom_range(0, 99);
    it.task_period = $urandom_range(1, 32'hFFFF_FFFF);
    if ($urandom_range(0, 99) < add_pct) begin
      it.command = CMD_ADD;
      // some duplicate ids, stored again as separate entries
      if (pick < 20 && stored > 0) it.task_id = tracker.chain_ids[$urandom_range(0, stored - 1)];
      else it.task_id = ID_W'($urandom_range(0, 16'hFFFF));
      if (stored < SMOOTH_UNTIL) it.task_period = smooth_period();
      else if (pick >= 90) it.task_period = (pick & 1) ? 32'hFFFF_FFFF : 32'd1;
    end else begin
      it.command = CMD_LOOKUP;
      // mostly hits, some on the newest id, the rest random (mostly misses)
      if (stored > 0 && pick < 55) it.task_id = tracker.chain_ids[$urandom_range(0, stored - 1)];
      else if (pick < 70) it.task_id = tracker.newest_id;
      else it.task_id = ID_W'($urandom_range(0, 16'hFFFF));
    end
    return it;
  endfunction

  task automatic run_phase(int count, int idle_pct, int add_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 60));
      send_item(random_item(add_pct));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty chain: lookups report nothing found, not last (even id 0, which
    // matches the reset last id), and the register value as hyperperiod.
    send_item(make_item(CMD_LOOKUP, 16'h0000, 32'd1));
    send_item(make_item(CMD_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF));
    drain();
    write_cfg(HP_MAX);
    send_item(make_item(CMD_LOOKUP, 16'h0000, 32'd7));
    drain();
    write_cfg(HP_W'({$urandom, $urandom}));
    send_item(make_item(CMD_LOOKUP, 16'h8001, 32'd7));
    drain();
    write_cfg(63'd1);
    send_item(make_item(CMD_ADD, 16'h0000, 32'd12));        // first period as is
    send_item(make_item(CMD_LOOKUP, 16'h0000, 32'd0));
    send_item(make_item(CMD_ADD, 16'hFFFF, 32'd18));        // gcd 6 -> 36
    send_item(make_item(CMD_LOOKUP, 16'h0000, 32'd0));      // found, not last
    send_item(make_item(CMD_LOOKUP, 16'hFFFF, 32'd0));      // found, last
    send_item(make_item(CMD_LOOKUP, 16'h1234, 32'd0));      // miss
    send_item(make_item(CMD_ADD, 16'hFFFF, 32'd36));        // duplicate id, divides
    send_item(make_item(CMD_ADD, 16'hA5A5, 32'd1));         // period 1
    send_item(make_item(CMD_ADD, 16'h5A5A, 32'hFFFF_FFFF)); // widest period
    send_item(make_item(CMD_LOOKUP, 16'hA5A5, 32'd0));
    send_item(make_item(CMD_LOOKUP, 16'h5A5A, 32'd0));

    // Random part: the chain fills early, saturates once periods go wide,
    // then adds are refused. The register is rewritten between phases.
    drain();
    write_cfg(HP_MAX);
    run_phase(600, 28, 2);
    drain();
    write_cfg('0);
    run_phase(600, 72, 3);
    drain();
    write_cfg(HP_W'({$urandom, $urandom}));
    run_phase(635, 0, 5);

    drain();
    // watch a while longer for stray strobes
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
